[rtl/ihp_pkg.sv]
// ----------------------------------------------------------------------------
// ihp_pkg
// Shared types and constants for the indexed min-heap.
// ----------------------------------------------------------------------------
`default_nettype none

package ihp_pkg;

    localparam int DEPTH        = 1024;
    localparam int HANDLE_WIDTH = 16;
    localparam int KEY_W        = 64;
    localparam int ADDR_W       = $clog2(DEPTH);
    localparam int CNT_W        = $clog2(DEPTH + 1);
    localparam int CH_W         = ADDR_W + 2;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_UPSERT = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_BAD_POS = 2'd2;

    typedef struct packed {
        logic [1:0]              command;
        logic [ADDR_W-1:0]       position;
        logic [KEY_W-1:0]        key_value;
        logic [HANDLE_WIDTH-1:0] owner_handle;
    } req_t;

    typedef struct packed {
        logic [HANDLE_WIDTH-1:0] moved_handle;
        logic [ADDR_W-1:0]       moved_position;
        logic                    move_valid;
        logic                    last_item;
        logic [1:0]              status;
        logic [CNT_W-1:0]        entry_count;
        logic [KEY_W-1:0]        top_value;
        logic [HANDLE_WIDTH-1:0] top_handle;
    } rsp_t;

    typedef struct packed {
        logic [KEY_W-1:0]        key;
        logic [HANDLE_WIDTH-1:0] handle;
    } entry_t;

    typedef struct packed {
        logic              rd_a_en;
        logic [ADDR_W-1:0] rd_a_addr;
        logic              rd_b_en;
        logic [ADDR_W-1:0] rd_b_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        entry_t            wr_data;
    } store_req_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_UP_RD,
        S_UP_CMP,
        S_DOWN_RD,
        S_DOWN_CMP,
        S_FINAL,
        S_NOP
    } state_t;

endpackage

`default_nettype wire

[rtl/indexed_min_heap.sv]
// ----------------------------------------------------------------------------
// indexed_min_heap
// Indexed binary min-heap of 64-bit keys with owner handles.
// Rejected commands, no-ops and removes of the last entry return a single beat.
// Others step through accept, a load of the last entry on a remove that moves it,
// a read and a compare per parent or child pair, a step each time the walk meets
// the root or a leaf, and a final beat; any beat may wait on rsp_ready.
// One command at a time: req_ready is high only while the sequencer is idle.
// Reset clears the count; entry memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_min_heap (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_ready,
    input  wire ihp_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_ready,
    output ihp_pkg::rsp_t      rsp
);

    ihp_pkg::store_req_t sreq;
    ihp_pkg::entry_t     rd_a;
    ihp_pkg::entry_t     rd_b;
    ihp_pkg::rsp_t       res;
    logic                emit_valid;
    logic                emit_ready;
    logic                out_valid_reg;
    ihp_pkg::rsp_t       out_reg;

    ihp_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .emit_valid (emit_valid),
        .emit_ready (emit_ready),
        .res        (res),
        .sreq       (sreq),
        .rd_a       (rd_a),
        .rd_b       (rd_b)
    );

    ihp_store u_store (
        .clk  (clk),
        .sreq (sreq),
        .rd_a (rd_a),
        .rd_b (rd_b)
    );

    // output beat register
    assign emit_ready = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_valid && emit_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_valid && emit_ready)
        begin
            out_reg <= res;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire

[rtl/ihp_store.sv]
// ----------------------------------------------------------------------------
// ihp_store
// Entry memory: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ihp_store (
    input  wire logic                clk,
    input  wire ihp_pkg::store_req_t sreq,
    output ihp_pkg::entry_t          rd_a,
    output ihp_pkg::entry_t          rd_b
);

    ihp_pkg::entry_t mem [ihp_pkg::DEPTH];
    ihp_pkg::entry_t rd_a_reg;
    ihp_pkg::entry_t rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (sreq.wr_en)
        begin
            mem[sreq.wr_addr] <= sreq.wr_data;
        end
        if (sreq.rd_a_en)
        begin
            rd_a_reg <= mem[sreq.rd_a_addr];
        end
        if (sreq.rd_b_en)
        begin
            rd_b_reg <= mem[sreq.rd_b_addr];
        end
    end

    assign rd_a = rd_a_reg;
    assign rd_b = rd_b_reg;

endmodule

`default_nettype wire

[rtl/ihp_seq.sv]
// ----------------------------------------------------------------------------
// ihp_seq
// Command sequencer: sift up/down over the entry memory, one level per step,
// one result beat per slot write.
// ----------------------------------------------------------------------------
`default_nettype none

module ihp_seq (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    output logic                     req_ready,
    input  wire ihp_pkg::req_t       req,
    output logic                     emit_valid,
    input  wire logic                emit_ready,
    output ihp_pkg::rsp_t            res,
    output ihp_pkg::store_req_t      sreq,
    input  wire ihp_pkg::entry_t     rd_a,
    input  wire ihp_pkg::entry_t     rd_b
);

    localparam int ADDR_W = ihp_pkg::ADDR_W;
    localparam int CNT_W  = ihp_pkg::CNT_W;
    localparam int CH_W   = ihp_pkg::CH_W;

    ihp_pkg::state_t                  state_reg, state_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic [ADDR_W-1:0]                slot_reg, slot_next;
    logic [ihp_pkg::KEY_W-1:0]        key_reg, key_next;
    logic [ihp_pkg::HANDLE_WIDTH-1:0] hnd_reg, hnd_next;
    logic [1:0]                       status_reg, status_next;
    logic                             settle_reg, settle_next;
    logic [ihp_pkg::KEY_W-1:0]        top_key_reg;
    logic [ihp_pkg::HANDLE_WIDTH-1:0] top_hnd_reg;

    logic [CNT_W-1:0]  count_m1;
    logic [CNT_W-1:0]  pos_ext;
    logic [ADDR_W-1:0] parent;
    logic [CH_W-1:0]   left_idx;
    logic [CH_W-1:0]   right_idx;
    logic              left_ok;
    logic              right_ok;
    logic              a_lt_k;
    logic              b_lt_k;
    logic              b_lt_a;
    logic              take_b;
    ihp_pkg::entry_t   emit_entry;

    assign count_m1  = count_reg - CNT_W'(1);
    assign pos_ext   = CNT_W'(req.position);
    assign parent    = (slot_reg - ADDR_W'(1)) >> 1;
    assign left_idx  = {1'b0, slot_reg, 1'b1};
    assign right_idx = left_idx + CH_W'(1);
    assign left_ok   = left_idx < CH_W'(count_reg);
    assign right_ok  = right_idx < CH_W'(count_reg);
    assign a_lt_k    = rd_a.key < key_reg;
    assign b_lt_k    = rd_b.key < key_reg;
    assign b_lt_a    = rd_b.key < rd_a.key;
    assign take_b    = right_ok && (a_lt_k ? b_lt_a : b_lt_k);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ihp_pkg::S_IDLE;
            count_reg  <= '0;
            settle_reg <= 1'b0;
            status_reg <= ihp_pkg::STAT_OK;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            settle_reg <= settle_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
        key_reg  <= key_next;
        hnd_reg  <= hnd_next;
        if (sreq.wr_en && sreq.wr_addr == '0)
        begin
            top_key_reg <= sreq.wr_data.key;
            top_hnd_reg <= sreq.wr_data.handle;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        slot_next   = slot_reg;
        key_next    = key_reg;
        hnd_next    = hnd_reg;
        status_next = status_reg;
        settle_next = settle_reg;
        req_ready   = 1'b0;
        emit_valid  = 1'b0;
        emit_entry  = {key_reg, hnd_reg};
        res         = '0;
        sreq        = '0;

        case (state_reg)
            ihp_pkg::S_IDLE:
            begin
                req_ready      = 1'b1;
                sreq.rd_a_addr = count_m1[ADDR_W-1:0];
                if (req_valid)
                begin
                    key_next    = req.key_value;
                    hnd_next    = req.owner_handle;
                    settle_next = 1'b1;
                    status_next = ihp_pkg::STAT_OK;
                    slot_next   = req.position;
                    case (req.command)
                        ihp_pkg::CMD_INSERT, ihp_pkg::CMD_UPSERT:
                        begin
                            if (req.command == ihp_pkg::CMD_UPSERT && pos_ext < count_reg)
                            begin
                                state_next = ihp_pkg::S_UP_RD;
                            end
                            else if (count_reg == CNT_W'(ihp_pkg::DEPTH))
                            begin
                                status_next = ihp_pkg::STAT_FULL;
                                state_next  = ihp_pkg::S_NOP;
                            end
                            else
                            begin
                                slot_next  = count_reg[ADDR_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                                state_next = ihp_pkg::S_UP_RD;
                            end
                        end
                        ihp_pkg::CMD_REMOVE:
                        begin
                            if (!(pos_ext < count_reg))
                            begin
                                status_next = ihp_pkg::STAT_BAD_POS;
                                state_next  = ihp_pkg::S_NOP;
                            end
                            else
                            begin
                                count_next = count_m1;
                                if (pos_ext == count_m1)
                                begin
                                    state_next = ihp_pkg::S_NOP;
                                end
                                else
                                begin
                                    sreq.rd_a_en = 1'b1;
                                    state_next   = ihp_pkg::S_LOAD;
                                end
                            end
                        end
                        default:
                        begin
                            state_next = ihp_pkg::S_NOP;
                        end
                    endcase
                end
            end

            ihp_pkg::S_LOAD:
            begin
                key_next   = rd_a.key;
                hnd_next   = rd_a.handle;
                state_next = ihp_pkg::S_UP_RD;
            end

            ihp_pkg::S_UP_RD:
            begin
                if (slot_reg == '0)
                begin
                    state_next = settle_reg ? ihp_pkg::S_DOWN_RD : ihp_pkg::S_FINAL;
                end
                else
                begin
                    sreq.rd_a_en   = 1'b1;
                    sreq.rd_a_addr = parent;
                    state_next     = ihp_pkg::S_UP_CMP;
                end
            end

            ihp_pkg::S_UP_CMP:
            begin
                if (rd_a.key > key_reg)
                begin
                    emit_valid = 1'b1;
                    emit_entry = rd_a;
                    if (emit_ready)
                    begin
                        slot_next   = parent;
                        settle_next = 1'b0;
                        state_next  = ihp_pkg::S_UP_RD;
                    end
                end
                else
                begin
                    state_next = settle_reg ? ihp_pkg::S_DOWN_RD : ihp_pkg::S_FINAL;
                end
            end

            ihp_pkg::S_DOWN_RD:
            begin
                if (left_ok)
                begin
                    sreq.rd_a_en   = 1'b1;
                    sreq.rd_a_addr = left_idx[ADDR_W-1:0];
                    sreq.rd_b_en   = 1'b1;
                    sreq.rd_b_addr = right_idx[ADDR_W-1:0];
                    state_next     = ihp_pkg::S_DOWN_CMP;
                end
                else
                begin
                    state_next = ihp_pkg::S_FINAL;
                end
            end

            ihp_pkg::S_DOWN_CMP:
            begin
                if (take_b || a_lt_k)
                begin
                    emit_valid = 1'b1;
                    emit_entry = take_b ? rd_b : rd_a;
                    if (emit_ready)
                    begin
                        slot_next  = take_b ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
                        state_next = ihp_pkg::S_DOWN_RD;
                    end
                end
                else
                begin
                    state_next = ihp_pkg::S_FINAL;
                end
            end

            ihp_pkg::S_FINAL:
            begin
                emit_valid = 1'b1;
                if (emit_ready)
                begin
                    state_next = ihp_pkg::S_IDLE;
                end
            end

            ihp_pkg::S_NOP:
            begin
                emit_valid = 1'b1;
                if (emit_ready)
                begin
                    state_next = ihp_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = ihp_pkg::S_IDLE;
            end
        endcase

        if (state_reg != ihp_pkg::S_NOP)
        begin
            res.moved_handle   = emit_entry.handle;
            res.moved_position = slot_reg;
            res.move_valid     = 1'b1;
        end

        if (state_reg == ihp_pkg::S_FINAL || state_reg == ihp_pkg::S_NOP)
        begin
            res.last_item   = 1'b1;
            res.status      = status_reg;
            res.entry_count = count_reg;
            if (state_reg == ihp_pkg::S_FINAL && slot_reg == '0)
            begin
                res.top_value  = key_reg;
                res.top_handle = hnd_reg;
            end
            else if (count_reg != '0)
            begin
                res.top_value  = top_key_reg;
                res.top_handle = top_hnd_reg;
            end
        end

        sreq.wr_en   = emit_valid && emit_ready && res.move_valid;
        sreq.wr_addr = slot_reg;
        sreq.wr_data = emit_entry;
    end

`ifndef ASSERT_OFF
    a_write_below_count: assert property (@(posedge clk) disable iff (!rst_n)
        sreq.wr_en |-> CNT_W'(sreq.wr_addr) < count_reg)
        else $error("slot write at or past count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(ihp_pkg::DEPTH))
        else $error("count past depth");

    a_count_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !(req_valid && req_ready) |=> $stable(count_reg))
        else $error("count changed without a command");

    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_valid && emit_ready && res.last_item) |=> state_reg == ihp_pkg::S_IDLE)
        else $error("sequencer busy after last beat");
`endif

endmodule

`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks indexed_min_heap against a behavioral heap model kept in the bench.
// Directed commands cover the empty heap, equal keys, the extreme keys and the
// last-slot and out-of-range removes. A random mix follows, then a growth phase
// of mostly ascending keys with a few small ones that climb from deep leaves.
// Every write-back beat is compared field by field, with bursty request traffic
// and response stalls.
// ----------------------------------------------------------------------------

module testbench;

    localparam int DEPTH        = ihp_pkg::DEPTH;
    localparam int HANDLE_WIDTH = ihp_pkg::HANDLE_WIDTH;
    localparam int KEY_W        = ihp_pkg::KEY_W;
    localparam int ADDR_W       = ihp_pkg::ADDR_W;
    localparam int CNT_W        = ihp_pkg::CNT_W;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int DRAIN_CYCLES    = 60;
    localparam int RANDOM_CMDS     = 260;
    localparam int FILL_CMDS       = 120;
    localparam int TAIL_CMDS       = 16;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_ready;
    ihp_pkg::req_t  req       = '0;
    logic           rsp_valid;
    logic           rsp_ready = 1'b0;
    ihp_pkg::rsp_t  rsp;

    indexed_min_heap dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // heap model
    logic [KEY_W-1:0]        slot_key   [DEPTH];
    logic [HANDLE_WIDTH-1:0] slot_owner [DEPTH];
    int   heap_size = 0;
    ihp_pkg::rsp_t expected_writebacks[$];

    ihp_pkg::req_t heap_cmds[$];
    int   planned_size = 0;

    int   mismatches    = 0;
    int   cmds_accepted = 0;
    int   beats_checked = 0;
    int   peak_size     = 0;
    int   full_rejects  = 0;
    int   bad_removes   = 0;
    int   nop_cmds      = 0;
    int   idle_cycles   = 0;

    int   burst_left  = 0;
    int   gap_left    = 0;
    int   hold_left   = 0;
    bit   ready_phase = 1'b0;
    ihp_pkg::rsp_t want;

    task automatic heap_write(input int slot, input logic [KEY_W-1:0] k,
                              input logic [HANDLE_WIDTH-1:0] h);
        ihp_pkg::rsp_t m;
        slot_key[slot]   = k;
        slot_owner[slot] = h;
        m                = '0;
        m.moved_handle   = h;
        m.moved_position = ADDR_W'(slot);
        m.move_valid     = 1'b1;
        expected_writebacks.insert(expected_writebacks.size(), m);
    endtask

    task automatic heap_settle(input int start);
        int slot;
        int parent;
        int child;
        int best;
        bit moving;
        logic [KEY_W-1:0]        k;
        logic [KEY_W-1:0]        bk;
        logic [HANDLE_WIDTH-1:0] h;
        slot = start;
        k    = slot_key[slot];
        h    = slot_owner[slot];
        if (slot > 0 && slot_key[(slot - 1) / 2] > k)
        begin
            while (slot > 0 && slot_key[(slot - 1) / 2] > k)
            begin
                parent = (slot - 1) / 2;
                heap_write(slot, slot_key[parent], slot_owner[parent]);
                slot = parent;
            end
        end
        else
        begin
            moving = 1'b1;
            while (moving)
            begin
                best  = slot;
                bk    = k;
                child = 2 * slot + 1;
                if (child < heap_size)
                begin
                    if (slot_key[child] < bk)
                    begin
                        best = child;
                        bk   = slot_key[child];
                    end
                end
                if (child + 1 < heap_size)
                begin
                    if (slot_key[child + 1] < bk)
                        best = child + 1;
                end
                if (best != slot)
                begin
                    heap_write(slot, slot_key[best], slot_owner[best]);
                    slot = best;
                end
                else
                    moving = 1'b0;
            end
        end
        heap_write(slot, k, h);
    endtask

    task automatic heap_apply(input ihp_pkg::req_t r);
        logic [1:0] st;
        int   base;
        int   pos;
        int   last;
        ihp_pkg::rsp_t fin;
        st   = ihp_pkg::STAT_OK;
        base = expected_writebacks.size();
        pos  = int'(r.position);
        case (r.command)
            ihp_pkg::CMD_INSERT, ihp_pkg::CMD_UPSERT:
            begin
                if (r.command == ihp_pkg::CMD_UPSERT && pos < heap_size)
                begin
                    slot_key[pos]   = r.key_value;
                    slot_owner[pos] = r.owner_handle;
                    heap_settle(pos);
                end
                else if (heap_size >= DEPTH)
                    st = ihp_pkg::STAT_FULL;
                else
                begin
                    slot_key[heap_size]   = r.key_value;
                    slot_owner[heap_size] = r.owner_handle;
                    heap_size++;
                    heap_settle(heap_size - 1);
                end
            end
            ihp_pkg::CMD_REMOVE:
            begin
                if (pos >= heap_size)
                    st = ihp_pkg::STAT_BAD_POS;
                else
                begin
                    last            = heap_size - 1;
                    slot_key[pos]   = slot_key[last];
                    slot_owner[pos] = slot_owner[last];
                    heap_size       = last;
                    if (pos < heap_size)
                        heap_settle(pos);
                end
            end
            default:
                nop_cmds++;
        endcase
        if (expected_writebacks.size() == base)
            fin = '0;
        else
        begin
            fin = expected_writebacks[expected_writebacks.size() - 1];
            expected_writebacks.delete(expected_writebacks.size() - 1);
        end
        fin.last_item   = 1'b1;
        fin.status      = st;
        fin.entry_count = CNT_W'(heap_size);
        if (heap_size > 0)
        begin
            fin.top_value  = slot_key[0];
            fin.top_handle = slot_owner[0];
        end
        expected_writebacks.insert(expected_writebacks.size(), fin);
        if (st == ihp_pkg::STAT_FULL)
            full_rejects++;
        if (st == ihp_pkg::STAT_BAD_POS)
            bad_removes++;
        if (heap_size > peak_size)
            peak_size = heap_size;
        cmds_accepted++;
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("[%0t] MISMATCH %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] exp_val);
        if (got !== exp_val)
            report_mismatch($sformatf("beat %0d %s: got %0h, expected %0h",
                                      beats_checked, name, got, exp_val));
    endtask

    // stimulus planning, tracking the heap size the commands will produce
    task automatic add_cmd(input logic [1:0] c, input int p, input logic [KEY_W-1:0] k,
                           input logic [HANDLE_WIDTH-1:0] h);
        ihp_pkg::req_t r;
        r.command      = c;
        r.position     = ADDR_W'(p);
        r.key_value    = k;
        r.owner_handle = h;
        case (c)
            ihp_pkg::CMD_INSERT:
                if (planned_size < DEPTH)
                    planned_size++;
            ihp_pkg::CMD_UPSERT:
                if (p >= planned_size && planned_size < DEPTH)
                    planned_size++;
            ihp_pkg::CMD_REMOVE:
                if (p < planned_size)
                    planned_size--;
            default: ;
        endcase
        heap_cmds.insert(heap_cmds.size(), r);
    endtask

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return KEY_W'($urandom_range(0, 15));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic int rand_pos();
        int sel;
        sel = $urandom_range(0, 9);
        if (planned_size >= DEPTH)
            return $urandom_range(0, DEPTH - 1);
        if (planned_size == 0 || sel == 0)
            return $urandom_range(planned_size, DEPTH - 1);
        if (sel == 1)
            return planned_size - 1;
        return $urandom_range(0, planned_size - 1);
    endfunction

    function automatic logic [HANDLE_WIDTH-1:0] rand_handle();
        return HANDLE_WIDTH'($urandom);
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
                heap_apply(req);
            if (!req_valid || req_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_valid <= 1'b0;
                end
                else if (heap_cmds.size() > 0)
                begin
                    req       <= heap_cmds.pop_front();
                    req_valid <= 1'b1;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 30);
                        gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 25);
                    end
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // response monitor and stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready <= 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                beats_checked++;
                if (expected_writebacks.size() == 0)
                    report_mismatch($sformatf("beat %0d arrived with nothing pending: %p",
                                              beats_checked, rsp));
                else
                begin
                    want = expected_writebacks.pop_front();
                    check_field("moved_handle", rsp.moved_handle, want.moved_handle);
                    check_field("moved_position", rsp.moved_position, want.moved_position);
                    check_field("move_valid", rsp.move_valid, want.move_valid);
                    check_field("last_item", rsp.last_item, want.last_item);
                    check_field("status", rsp.status, want.status);
                    check_field("entry_count", rsp.entry_count, want.entry_count);
                    check_field("top_value", rsp.top_value, want.top_value);
                    check_field("top_handle", rsp.top_handle, want.top_handle);
                end
            end
            if (hold_left > 0)
                hold_left--;
            else
            begin
                ready_phase = !ready_phase;
                if (ready_phase)
                    hold_left = $urandom_range(0, 40);
                else
                    hold_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20)
                                                            : $urandom_range(0, 1);
            end
            rsp_ready <= ready_phase;
        end
    end

    // watchdog on progress of either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] timeout: no beat for %0d cycles, %0d beats outstanding",
                         $realtime, idle_cycles, expected_writebacks.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        // directed: empty heap, extremes, equal keys, last slot, out of range
        add_cmd(ihp_pkg::CMD_REMOVE, 0, '1, '1);
        add_cmd(CMD_NOP, 1023, '1, '1);
        add_cmd(ihp_pkg::CMD_UPSERT, 1023, '1, 16'hffff);
        add_cmd(ihp_pkg::CMD_INSERT, 1023, '0, 16'h0000);
        add_cmd(ihp_pkg::CMD_INSERT, 0, '0, 16'h0001);
        add_cmd(ihp_pkg::CMD_INSERT, 0, 64'haaaa_aaaa_aaaa_aaaa, 16'haaaa);
        add_cmd(ihp_pkg::CMD_INSERT, 0, 64'h5555_5555_5555_5555, 16'h5555);
        add_cmd(ihp_pkg::CMD_INSERT, 0, 64'd7, 16'h0007);
        add_cmd(ihp_pkg::CMD_INSERT, 0, 64'd7, 16'h0008);
        add_cmd(ihp_pkg::CMD_UPSERT, 0, '1, 16'h00f0);
        add_cmd(ihp_pkg::CMD_UPSERT, 3, '0, 16'h00f1);
        add_cmd(ihp_pkg::CMD_UPSERT, 1, 64'd7, 16'h00f2);
        add_cmd(ihp_pkg::CMD_UPSERT, planned_size, 64'd3, 16'h00f3);
        add_cmd(ihp_pkg::CMD_REMOVE, planned_size - 1, '0, '0);
        add_cmd(ihp_pkg::CMD_REMOVE, 0, '0, '0);
        add_cmd(ihp_pkg::CMD_REMOVE, 1023, '0, '0);
        add_cmd(ihp_pkg::CMD_REMOVE, planned_size, '1, '1);
        add_cmd(CMD_NOP, 0, '0, '0);
        add_cmd(ihp_pkg::CMD_REMOVE, 1, '0, '0);
        add_cmd(ihp_pkg::CMD_INSERT, 0, 64'd7, 16'h0009);
        add_cmd(ihp_pkg::CMD_UPSERT, 0, 64'h8000_0000_0000_0000, 16'h00f4);

        for (int i = 0; i < RANDOM_CMDS; i++)
        begin
            int sel;
            sel = $urandom_range(0, 99);
            if (sel < 42)
                add_cmd(ihp_pkg::CMD_INSERT, $urandom_range(0, DEPTH - 1), rand_key(),
                        rand_handle());
            else if (sel < 64)
                add_cmd(ihp_pkg::CMD_UPSERT, rand_pos(), rand_key(), rand_handle());
            else if (sel < 95)
                add_cmd(ihp_pkg::CMD_REMOVE, rand_pos(), rand_key(), rand_handle());
            else
                add_cmd(CMD_NOP, $urandom_range(0, DEPTH - 1), rand_key(), rand_handle());
        end

        // growth: mostly ascending keys, some small ones that climb
        for (int n = 0; n < FILL_CMDS; n++)
        begin
            if ($urandom_range(0, 31) == 0)
                add_cmd(ihp_pkg::CMD_INSERT, 0, {32'h0, $urandom}, rand_handle());
            else
                add_cmd(ihp_pkg::CMD_INSERT, 0, 64'h0100_0000_0000_0000 + 64'(n) * 64'h1_0000
                        + 64'($urandom_range(0, 255)), rand_handle());
        end
        repeat (3)
            add_cmd(ihp_pkg::CMD_INSERT, $urandom_range(0, DEPTH - 1), rand_key(),
                    rand_handle());
        add_cmd(ihp_pkg::CMD_UPSERT, DEPTH - 1, '0, rand_handle());
        for (int i = 0; i < TAIL_CMDS; i++)
        begin
            int sel;
            sel = $urandom_range(0, 9);
            if (sel < 6)
                add_cmd(ihp_pkg::CMD_REMOVE, rand_pos(), rand_key(), rand_handle());
            else if (sel < 8)
                add_cmd(ihp_pkg::CMD_UPSERT, rand_pos(), rand_key(), rand_handle());
            else
                add_cmd(ihp_pkg::CMD_INSERT, 0, rand_key(), rand_handle());
        end

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (heap_cmds.size() != 0 || req_valid || expected_writebacks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_writebacks.size() != 0)
            report_mismatch($sformatf("%0d beats never arrived", expected_writebacks.size()));

        $display("Coverage: %0d commands, %0d write-back beats, heap peaked at %0d entries",
                 cmds_accepted, beats_checked, peak_size);
        $display("          %0d full-heap rejects, %0d out-of-range removes, %0d no-ops",
                 full_rejects, bad_removes, nop_cmds);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[indexed_min_heap.f]
rtl/ihp_pkg.sv
rtl/ihp_store.sv
rtl/ihp_seq.sv
rtl/indexed_min_heap.sv
tb/testbench.sv
